@@ sv/wcalj_pkg.sv @@
`timescale 1ns / 1ps

package wcalj_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 2'd2;

	localparam int MUL_W = 64;
	localparam int SAT_W = 59;
	localparam logic [SAT_W-1:0] SAT_LIM = {1'b1, {(SAT_W-1){1'b0}}};

	localparam real CUT_ROOT = 1.122462048309373;

endpackage

@@ sv/wcalj_div.sv @@
`timescale 1ns / 1ps

module wcalj_div #(
	parameter int LANES = 1,
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int QW = 33,
	parameter int SW = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_in,
	input  logic [LANES-1:0][NW-1:0]     num_in,
	input  logic [LANES-1:0][DW-1:0]     den_in,
	input  logic [SW-1:0]                side_in,
	output logic                         vld_out,
	output logic [LANES-1:0][QW-1:0]     quo_out,
	output logic [LANES-1:0][NW-1:0]     rem_out,
	output logic [SW-1:0]                side_out
);

	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic                     vld_s  [1:QW];
	logic [LANES-1:0][NW-1:0] rem_s  [1:QW];
	logic [LANES-1:0][DW-1:0] den_s  [1:QW];
	logic [LANES-1:0][QW-1:0] quo_s  [1:QW];
	logic [SW-1:0]            side_s [1:QW];

	logic [LANES-1:0][NW-1:0] rem_c  [QW];
	logic [LANES-1:0][DW-1:0] den_c  [QW];
	logic [LANES-1:0][QW-1:0] quo_c  [QW];
	logic [SW-1:0]            side_c [QW];
	logic [LANES-1:0][NW-1:0] nrem_c [QW];
	logic [LANES-1:0][QW-1:0] nquo_c [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		localparam int B = QW - 1 - g;

		if (g == 0) begin : g_head
			assign rem_c[g]  = num_in;
			assign den_c[g]  = den_in;
			assign quo_c[g]  = '0;
			assign side_c[g] = side_in;
		end else begin : g_body
			assign rem_c[g]  = rem_s[g];
			assign den_c[g]  = den_s[g];
			assign quo_c[g]  = quo_s[g];
			assign side_c[g] = side_s[g];
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [CW-1:0] sh;
			logic          take;
			assign sh   = CW'(den_c[g][l]) << B;
			assign take = CW'(rem_c[g][l]) >= sh;
			assign nrem_c[g][l] = take ? NW'(CW'(rem_c[g][l]) - sh) : rem_c[g][l];
			assign nquo_c[g][l] = quo_c[g][l] | (QW'(take) << B);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= QW; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= vld_in;
			for (int i = 2; i <= QW; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QW; i++) begin
				rem_s[i+1]  <= nrem_c[i];
				den_s[i+1]  <= den_c[i];
				quo_s[i+1]  <= nquo_c[i];
				side_s[i+1] <= side_c[i];
			end
		end
	end

	assign vld_out  = vld_s[QW];
	assign quo_out  = quo_s[QW];
	assign rem_out  = rem_s[QW];
	assign side_out = side_s[QW];

endmodule

@@ sv/wcalj_isqrt.sv @@
`timescale 1ns / 1ps

module wcalj_isqrt #(
	parameter int RW = 64,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [RW-1:0]     rad_in,
	input  logic [SW-1:0]     side_in,
	output logic              vld_out,
	output logic [RW/2-1:0]   root_out,
	output logic [SW-1:0]     side_out
);

	localparam int STEPS = RW / 2;

	logic          vld_s  [1:STEPS];
	logic [RW-1:0] v_s    [1:STEPS];
	logic [RW-1:0] r_s    [1:STEPS];
	logic [SW-1:0] side_s [1:STEPS];

	logic [RW-1:0] v_c    [STEPS];
	logic [RW-1:0] r_c    [STEPS];
	logic [SW-1:0] side_c [STEPS];
	logic [RW-1:0] nv_c   [STEPS];
	logic [RW-1:0] nr_c   [STEPS];

	for (genvar g = 0; g < STEPS; g++) begin : g_stage
		localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * g);
		logic [RW-1:0] t;
		logic          take;

		if (g == 0) begin : g_head
			assign v_c[g]    = rad_in;
			assign r_c[g]    = '0;
			assign side_c[g] = side_in;
		end else begin : g_body
			assign v_c[g]    = v_s[g];
			assign r_c[g]    = r_s[g];
			assign side_c[g] = side_s[g];
		end

		assign t       = r_c[g] + BIT;
		assign take    = v_c[g] >= t;
		assign nv_c[g] = take ? v_c[g] - t : v_c[g];
		assign nr_c[g] = take ? (r_c[g] >> 1) + BIT : r_c[g] >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= STEPS; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= vld_in;
			for (int i = 2; i <= STEPS; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < STEPS; i++) begin
				v_s[i+1]    <= nv_c[i];
				r_s[i+1]    <= nr_c[i];
				side_s[i+1] <= side_c[i];
			end
		end
	end

	assign vld_out  = vld_s[STEPS];
	assign root_out = r_s[STEPS][RW/2-1:0];
	assign side_out = side_s[STEPS];

endmodule

@@ sv/wcalj_mulq.sv @@
`timescale 1ns / 1ps

module wcalj_mulq #(
	parameter int LANES = 1,
	parameter int FRAC_BITS = 16,
	parameter int SW = 1
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    vld_in,
	input  logic [LANES-1:0][wcalj_pkg::MUL_W-1:0]  a_in,
	input  logic [LANES-1:0][wcalj_pkg::MUL_W-1:0]  b_in,
	input  logic [SW-1:0]                           side_in,
	output logic                                    vld_out,
	output logic [LANES-1:0][wcalj_pkg::SAT_W-1:0]  prod_out,
	output logic [SW-1:0]                           side_out
);

	localparam int MW = wcalj_pkg::MUL_W;
	localparam int HW = MW / 2;
	localparam int PW = 2 * MW;
	localparam int RW = PW - FRAC_BITS;

	logic                                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic [SW-1:0]                          side_s1, side_s2, side_s3, side_s4;
	logic [LANES-1:0][MW-1:0]               p00_s1, p01_s1, p10_s1, p11_s1;
	logic [LANES-1:0][MW:0]                 mid_s2;
	logic [LANES-1:0][PW-1:0]               cat_s2;
	logic [LANES-1:0][PW-1:0]               full_s3;
	logic [LANES-1:0][wcalj_pkg::SAT_W-1:0] res_s4;
	logic [LANES-1:0][RW-1:0]               shr;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			shr[l] = full_s3[l][PW-1:FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			for (int l = 0; l < LANES; l++) begin
				p00_s1[l]  <= a_in[l][HW-1:0] * b_in[l][HW-1:0];
				p01_s1[l]  <= a_in[l][HW-1:0] * b_in[l][MW-1:HW];
				p10_s1[l]  <= a_in[l][MW-1:HW] * b_in[l][HW-1:0];
				p11_s1[l]  <= a_in[l][MW-1:HW] * b_in[l][MW-1:HW];
				mid_s2[l]  <= (MW+1)'(p01_s1[l]) + (MW+1)'(p10_s1[l]);
				cat_s2[l]  <= {p11_s1[l], p00_s1[l]};
				full_s3[l] <= cat_s2[l] + (PW'(mid_s2[l]) << HW);
				res_s4[l]  <= (shr[l] > RW'(wcalj_pkg::SAT_LIM)) ? wcalj_pkg::SAT_LIM
					: shr[l][wcalj_pkg::SAT_W-1:0];
			end
		end
	end

	assign vld_out  = vld_s4;
	assign prod_out = res_s4;
	assign side_out = side_s4;

endmodule

@@ sv/wca_lennard_jones_pair_force.sv @@
`timescale 1ns / 1ps

// Repulsive Lennard-Jones (WCA) pair force with minimum-image wrapping, all in
// Q.FRAC_BITS fixed point. One pair may enter every clock while the output
// is not stalled. The pipeline is built from the bit-per-stage dividers (wrap
// and reciprocal), the 32-stage square root and seven 4-stage fractional
// multiplies. A stall on a valid output freezes the whole pipeline and stalls
// the input. Registers (strength, cap distance, cutoff distance) are written
// through the cfg port, which is always ready, and must only change while no
// pair is in flight.
module wca_lennard_jones_pair_force #(
	parameter int FRAC_BITS = wcalj_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [31:0]                 first_x,
	input  logic signed [31:0]                 first_y,
	input  logic signed [31:0]                 first_z,
	input  logic signed [31:0]                 second_x,
	input  logic signed [31:0]                 second_y,
	input  logic signed [31:0]                 second_z,
	input  logic [31:0]                        first_radius,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [31:0]                 force_x,
	output logic signed [31:0]                 force_y,
	output logic signed [31:0]                 force_z,
	output logic                               within_cutoff,
	output logic                               saturated,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wcalj_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wcalj_pkg::DATA_W-1:0]       cfg_data
);

	localparam int DW = wcalj_pkg::DATA_W;
	localparam int MW = wcalj_pkg::MUL_W;
	localparam int SW = wcalj_pkg::SAT_W;
	localparam int LQW = DW + 1;
	localparam int WNW = DW + 3;
	localparam int WDW = LQW + 1;
	localparam int WQW = 34 - FRAC_BITS;
	localparam int SQW = 2 * DW;
	localparam int RNW = DW + FRAC_BITS;
	localparam int IW = 2 * FRAC_BITS + 1;
	localparam int UW = FRAC_BITS + 1;
	localparam int TRW = 5 + 3 * UW;
	localparam int PNW = SW + 4;

	localparam logic [DW-1:0] RST_STRENGTH = DW'(5 << FRAC_BITS);
	localparam logic [DW-1:0] RST_CAP = DW'(((8 << FRAC_BITS) + 5) / 10);
	localparam logic [DW-1:0] RST_CUTOFF =
		DW'(longint'(wcalj_pkg::CUT_ROOT * (2.0 ** FRAC_BITS)));

	logic [DW-1:0] strength_q, cap_q, cutoff_q;
	logic          pipe_en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= RST_STRENGTH;
			cap_q      <= RST_CAP;
			cutoff_q   <= RST_CUTOFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wcalj_pkg::REG_STRENGTH: strength_q <= cfg_data;
				wcalj_pkg::REG_CAP:      cap_q      <= cfg_data;
				wcalj_pkg::REG_CUTOFF:   cutoff_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	assign pipe_en  = !vld_s10 || !out_stall;
	assign in_stall = !pipe_en;

	// stage 1: separation
	logic [2:0][DW-1:0] pa, pb;
	logic [2:0][DW:0]   dlt;
	logic [2:0]         neg_c;
	logic [2:0][DW-1:0] mag_c;
	logic [LQW-1:0]     lq_c;

	assign pa = {first_z, first_y, first_x};
	assign pb = {second_z, second_y, second_x};
	assign lq_c = LQW'(first_radius >> (FRAC_BITS - 1)) << FRAC_BITS;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dlt[k]   = {pa[k][DW-1], pa[k]} - {pb[k][DW-1], pb[k]};
			neg_c[k] = dlt[k][DW];
			mag_c[k] = dlt[k][DW] ? DW'(~dlt[k] + 1'b1) : dlt[k][DW-1:0];
		end
	end

	logic [2:0]         neg_s1, neg_s2;
	logic [2:0][DW-1:0] mag_s1, mag_s2;
	logic [LQW-1:0]     lq_s1, lq_s2;
	logic [2:0][WNW-1:0] num_s2;
	logic [WDW-1:0]     den_s2;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			neg_s1 <= neg_c;
			mag_s1 <= mag_c;
			lq_s1  <= lq_c;
			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
			lq_s2  <= lq_s1;
			den_s2 <= {lq_s1, 1'b0};
			for (int k = 0; k < 3; k++) begin
				num_s2[k] <= WNW'({mag_s1[k], 1'b0}) + WNW'(lq_s1);
			end
		end
	end

	// minimum image: remainder of (2|d| + L) by 2L
	logic                 vld_w1;
	logic [2:0][WQW-1:0]  quo_w1;
	logic [2:0][WNW-1:0]  rem_w1;
	logic [2:0]           neg_w1;
	logic [2:0][DW-1:0]   mag_w1;
	logic [LQW-1:0]       lq_w1;

	wcalj_div #(
		.LANES (3),
		.NW    (WNW),
		.DW    (WDW),
		.QW    (WQW),
		.SW    (3 + 3 * DW + LQW)
	) u_wrap_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.vld_in   (vld_s2),
		.num_in   (num_s2),
		.den_in   ({3{den_s2}}),
		.side_in  ({neg_s2, mag_s2, lq_s2}),
		.vld_out  (vld_w1),
		.quo_out  (quo_w1),
		.rem_out  (rem_w1),
		.side_out ({neg_w1, mag_w1, lq_w1})
	);

	logic signed [WNW:0] sdf [3];
	logic signed [WNW:0] tw  [3];
	logic [2:0]          neg_c3;
	logic [2:0][DW-1:0]  mag_c3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sdf[k] = signed'((WNW+1)'(rem_w1[k]) - (WNW+1)'(lq_w1));
			tw[k]  = sdf[k] >>> 1;
			if (lq_w1 == '0) begin
				neg_c3[k] = neg_w1[k];
				mag_c3[k] = mag_w1[k];
			end else begin
				neg_c3[k] = neg_w1[k] ? ((tw[k] != '0) && !tw[k][WNW]) : tw[k][WNW];
				mag_c3[k] = tw[k][WNW] ? DW'(-tw[k]) : tw[k][DW-1:0];
			end
		end
	end

	// stages 3..6: cutoff test and sum of squares
	logic [2:0]          neg_s3, neg_s4, neg_s5, neg_s6;
	logic [2:0][DW-1:0]  mag_s3, mag_s4, mag_s5, mag_s6;
	logic                in0_s4, in0_s5, within_s6, zero_s6;
	logic [2:0][SQW-1:0] sq_s4;
	logic [SQW-1:0]      csq_s4, csq_s5, rad_s6;
	logic [SQW+1:0]      sum_s5;
	logic                in0_c;

	always_comb begin
		in0_c = cutoff_q != '0;
		for (int k = 0; k < 3; k++) begin
			if (mag_s3[k] > cutoff_q) begin
				in0_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			neg_s3    <= neg_c3;
			mag_s3    <= mag_c3;
			neg_s4    <= neg_s3;
			mag_s4    <= mag_s3;
			in0_s4    <= in0_c;
			csq_s4    <= cutoff_q * cutoff_q;
			for (int k = 0; k < 3; k++) begin
				sq_s4[k] <= mag_s3[k] * mag_s3[k];
			end
			neg_s5    <= neg_s4;
			mag_s5    <= mag_s4;
			in0_s5    <= in0_s4;
			csq_s5    <= csq_s4;
			sum_s5    <= (SQW+2)'(sq_s4[0]) + (SQW+2)'(sq_s4[1]) + (SQW+2)'(sq_s4[2]);
			neg_s6    <= neg_s5;
			mag_s6    <= mag_s5;
			within_s6 <= in0_s5 && (sum_s5 < (SQW+2)'(csq_s5));
			zero_s6   <= sum_s5 == '0;
			rad_s6    <= sum_s5[SQW-1:0];
		end
	end

	logic               vld_r;
	logic [DW-1:0]      dist_r;
	logic [2:0]         neg_r;
	logic [2:0][DW-1:0] mag_r;
	logic               within_r, zero_r;

	wcalj_isqrt #(
		.RW (SQW),
		.SW (3 + 3 * DW + 2)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.vld_in   (vld_s6),
		.rad_in   (rad_s6),
		.side_in  ({neg_s6, mag_s6, within_s6, zero_s6}),
		.vld_out  (vld_r),
		.root_out (dist_r),
		.side_out ({neg_r, mag_r, within_r, zero_r})
	);

	// stage 7: reciprocal and unit-vector divides
	logic [3:0][RNW-1:0] num_s7;
	logic [3:0][DW-1:0]  den_s7;
	logic [2:0]          neg_s7;
	logic                within_s7, zero_s7;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			num_s7[0] <= RNW'(1) << (2 * FRAC_BITS);
			den_s7[0] <= (dist_r <= cap_q) ? cap_q : dist_r;
			for (int k = 0; k < 3; k++) begin
				num_s7[k+1] <= RNW'(mag_r[k]) << FRAC_BITS;
				den_s7[k+1] <= dist_r;
			end
			neg_s7    <= neg_r;
			within_s7 <= within_r;
			zero_s7   <= zero_r;
		end
	end

	logic                vld_v;
	logic [3:0][IW-1:0]  quo_v;
	logic [3:0][RNW-1:0] rem_v;
	logic [2:0]          neg_v;
	logic                within_v, zero_v;
	logic [2:0][UW-1:0]  unit_v;
	logic [TRW-1:0]      tr_v;

	wcalj_div #(
		.LANES (4),
		.NW    (RNW),
		.DW    (DW),
		.QW    (IW),
		.SW    (5)
	) u_recip_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.vld_in   (vld_s7),
		.num_in   (num_s7),
		.den_in   (den_s7),
		.side_in  ({neg_s7, within_s7, zero_s7}),
		.vld_out  (vld_v),
		.quo_out  (quo_v),
		.rem_out  (rem_v),
		.side_out ({neg_v, within_v, zero_v})
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			unit_v[k] = quo_v[k+1][UW-1:0];
		end
	end

	assign tr_v = {neg_v, within_v, zero_v, unit_v};

	// power chain: inv^2, inv^4, inv^6, inv^7, inv^13
	logic          vld_m1, vld_m2, vld_m3, vld_m4, vld_m5, vld_m6, vld_m7;
	logic [TRW-1:0] tr_m1, tr_m2, tr_m3, tr_m4, tr_m5, tr_m6;
	logic [IW-1:0] inv_m1, inv_m2, inv_m3;
	logic [SW-1:0] inv2_m1, inv2_m2, inv4_m2, inv6_m3, inv6_m4, inv7_m4, inv7_m5;
	logic [SW-1:0] inv13_m5, cmag_m6;
	logic          cneg_m6;

	wcalj_mulq #(.LANES(1), .FRAC_BITS(FRAC_BITS), .SW(TRW + IW)) u_mul_inv2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.vld_in   (vld_v),
		.a_in     (MW'(quo_v[0])),
		.b_in     (MW'(quo_v[0])),
		.side_in  ({tr_v, quo_v[0]}),
		.vld_out  (vld_m1),
		.prod_out (inv2_m1),
		.side_out ({tr_m1, inv_m1})
	);

	wcalj_mulq #(.LANES(1), .FRAC_BITS(FRAC_BITS), .SW(TRW + IW + SW)) u_mul_inv4 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.vld_in   (vld_m1),
		.a_in     (MW'(inv2_m1)),
		.b_in     (MW'(inv2_m1)),
		.side_in  ({tr_m1, inv_m1, inv2_m1}),
		.vld_out  (vld_m2),
		.prod_out (inv4_m2),
		.side_out ({tr_m2, inv_m2, inv2_m2})
	);

	wcalj_mulq #(.LANES(1), .FRAC_BITS(FRAC_BITS), .SW(TRW + IW)) u_mul_inv6 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.vld_in   (vld_m2),
		.a_in     (MW'(inv4_m2)),
		.b_in     (MW'(inv2_m2)),
		.side_in  ({tr_m2, inv_m2}),
		.vld_out  (vld_m3),
		.prod_out (inv6_m3),
		.side_out ({tr_m3, inv_m3})
	);

	wcalj_mulq #(.LANES(1), .FRAC_BITS(FRAC_BITS), .SW(TRW + SW)) u_mul_inv7 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.vld_in   (vld_m3),
		.a_in     (MW'(inv6_m3)),
		.b_in     (MW'(inv_m3)),
		.side_in  ({tr_m3, inv6_m3}),
		.vld_out  (vld_m4),
		.prod_out (inv7_m4),
		.side_out ({tr_m4, inv6_m4})
	);

	wcalj_mulq #(.LANES(1), .FRAC_BITS(FRAC_BITS), .SW(TRW + SW)) u_mul_inv13 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.vld_in   (vld_m4),
		.a_in     (MW'(inv6_m4)),
		.b_in     (MW'(inv7_m4)),
		.side_in  ({tr_m4, inv7_m4}),
		.vld_out  (vld_m5),
		.prod_out (inv13_m5),
		.side_out ({tr_m5, inv7_m5})
	);

	// stages 8, 9: 12/r^13 - 6/r^7 as sign and magnitude
	logic [PNW-1:0] pos_s8, neg_s8, diff_s9;
	logic [TRW-1:0] tr_s8, tr_s9;
	logic           cneg_s9;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pos_s8  <= (PNW'(inv13_m5) << 3) + (PNW'(inv13_m5) << 2);
			neg_s8  <= (PNW'(inv7_m5) << 2) + (PNW'(inv7_m5) << 1);
			tr_s8   <= tr_m5;
			cneg_s9 <= pos_s8 < neg_s8;
			diff_s9 <= (pos_s8 < neg_s8) ? neg_s8 - pos_s8 : pos_s8 - neg_s8;
			tr_s9   <= tr_s8;
		end
	end

	wcalj_mulq #(.LANES(1), .FRAC_BITS(FRAC_BITS), .SW(TRW + 1)) u_mul_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.vld_in   (vld_s9),
		.a_in     (MW'(strength_q)),
		.b_in     (MW'(diff_s9)),
		.side_in  ({tr_s9, cneg_s9}),
		.vld_out  (vld_m6),
		.prod_out (cmag_m6),
		.side_out ({tr_m6, cneg_m6})
	);

	logic [2:0]          neg_f;
	logic                within_f, zero_f;
	logic [2:0][UW-1:0]  unit_f;
	logic [2:0][MW-1:0]  ca_f, ub_f;

	assign {neg_f, within_f, zero_f, unit_f} = tr_m6;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ca_f[k] = MW'(cmag_m6);
			ub_f[k] = MW'(unit_f[k]);
		end
	end

	logic [2:0][SW-1:0] fmag_m7;
	logic [2:0]         neg_o;
	logic               within_o, zero_o, cneg_o;

	wcalj_mulq #(.LANES(3), .FRAC_BITS(FRAC_BITS), .SW(6)) u_mul_force (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.vld_in   (vld_m6),
		.a_in     (ca_f),
		.b_in     (ub_f),
		.side_in  ({neg_f, within_f, zero_f, cneg_m6}),
		.vld_out  (vld_m7),
		.prod_out (fmag_m7),
		.side_out ({neg_o, within_o, zero_o, cneg_o})
	);

	// stage 10: sign, clip, output register
	logic [2:0]          fneg_c, clip_c;
	logic [2:0][SW-1:0]  lim_c;
	logic [2:0][DW-1:0]  fm_c, frc_c;
	logic                act_c;
	logic [2:0][DW-1:0]  force_s10;
	logic                within_s10, sat_s10;

	assign act_c = within_o && !zero_o;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			fneg_c[k] = cneg_o ^ neg_o[k];
			lim_c[k]  = fneg_c[k] ? SW'(33'h080000000) : SW'(33'h07fffffff);
			clip_c[k] = fmag_m7[k] > lim_c[k];
			fm_c[k]   = clip_c[k] ? lim_c[k][DW-1:0] : fmag_m7[k][DW-1:0];
			frc_c[k]  = fneg_c[k] ? (~fm_c[k] + 1'b1) : fm_c[k];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			for (int k = 0; k < 3; k++) begin
				force_s10[k] <= act_c ? frc_c[k] : '0;
			end
			within_s10 <= within_o;
			sat_s10    <= act_c && (clip_c != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_w1;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_r;
			vld_s8  <= vld_m5;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_m7;
		end
	end

	assign out_valid     = vld_s10;
	assign force_x       = force_s10[0];
	assign force_y       = force_s10[1];
	assign force_z       = force_s10[2];
	assign within_cutoff = within_s10;
	assign saturated     = sat_s10;

`ifndef SYNTH
	a_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !within_cutoff |->
			force_x == '0 && force_y == '0 && force_z == '0 && !saturated)
		else $error("force beyond cutoff");

	a_sat_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> within_cutoff)
		else $error("clip flagged beyond cutoff");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s1)
		else $error("accepted beat lost at entry");
`endif

endmodule

@@ verif/tb_wca_lennard_jones_pair_force.sv @@
`timescale 1ns / 1ps

module tb_wca_lennard_jones_pair_force;

	localparam int FRAC = wcalj_pkg::FRAC_BITS_DEF;
	localparam int DRAIN_CYCLES = 140;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [31:0] STRENGTH_RST = 32'd327680;
	localparam logic [31:0] CAP_RST = 32'd52429;
	localparam logic [31:0] CUTOFF_RST = 32'd73562;

	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
		logic [31:0] first_radius;
	} pair_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic within_cutoff;
		logic saturated;
	} force_t;

	class force_scoreboard;
		force_t expected_forces[$];
		logic [31:0] strength = STRENGTH_RST;
		logic [31:0] cap_distance = CAP_RST;
		logic [31:0] cutoff_distance = CUTOFF_RST;
		int fails = 0;

		function void write_reg(logic [wcalj_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
			case (idx)
				wcalj_pkg::REG_STRENGTH: strength = value;
				wcalj_pkg::REG_CAP: cap_distance = value;
				wcalj_pkg::REG_CUTOFF: cutoff_distance = value;
				default: ;
			endcase
		endfunction

		function bit [63:0] qmul(bit [63:0] a, bit [63:0] b);
			bit [127:0] prod;
			prod = ({64'b0, a} * {64'b0, b}) >> FRAC;
			return (prod > 128'(wcalj_pkg::SAT_LIM)) ? 64'(wcalj_pkg::SAT_LIM) : prod[63:0];
		endfunction

		function bit [63:0] int_sqrt(bit [63:0] v);
			bit [63:0] root, bitv;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv >>= 2;
			while (bitv != 0) begin
				if (v >= root + bitv) begin
					v -= root + bitv;
					root = (root >> 1) + bitv;
				end else begin
					root >>= 1;
				end
				bitv >>= 2;
			end
			return root;
		endfunction

		function force_t pair_force(pair_t p);
			longint d[3];
			longint pa[3];
			longint pb[3];
			bit [63:0] mag[3];
			bit [63:0] fv[3];
			bit [63:0] lq, n, sum, root_d, rc, inv, i2, i4, i6, i7, i13, pos, neg, cmag;
			bit [63:0] unit, fmag, lim;
			bit [65:0] acc;
			bit in_cut, sat, cneg, fneg;
			force_t r;
			pa = '{longint'(p.first_x), longint'(p.first_y), longint'(p.first_z)};
			pb = '{longint'(p.second_x), longint'(p.second_y), longint'(p.second_z)};
			lq = 64'(p.first_radius >> (FRAC - 1)) << FRAC;
			sat = 0;
			fv = '{0, 0, 0};
			for (int k = 0; k < 3; k++) begin
				d[k] = pa[k] - pb[k];
				mag[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
				if (lq != 0) begin
					n = (2 * mag[k] + lq) / (2 * lq);
					d[k] = d[k] < 0 ? d[k] + longint'(n * lq) : d[k] - longint'(n * lq);
					mag[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
				end
			end
			in_cut = cutoff_distance != 0;
			for (int k = 0; k < 3; k++)
				if (mag[k] > 64'(cutoff_distance))
					in_cut = 0;
			sum = 0;
			if (in_cut) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += 66'(mag[k] * mag[k]);
				sum = acc > 66'({64{1'b1}}) ? {64{1'b1}} : acc[63:0];
				in_cut = sum < 64'(cutoff_distance) * 64'(cutoff_distance);
			end
			if (in_cut && sum != 0) begin
				root_d = int_sqrt(sum);
				rc = root_d <= 64'(cap_distance) ? 64'(cap_distance) : root_d;
				inv = (64'd1 << (2 * FRAC)) / rc;
				i2 = qmul(inv, inv);
				i4 = qmul(i2, i2);
				i6 = qmul(i4, i2);
				i7 = qmul(i6, inv);
				i13 = qmul(i6, i7);
				pos = 12 * i13;
				neg = 6 * i7;
				cneg = pos < neg;
				cmag = cneg ? qmul(64'(strength), neg - pos) : qmul(64'(strength), pos - neg);
				for (int k = 0; k < 3; k++) begin
					unit = (mag[k] << FRAC) / root_d;
					fmag = qmul(cmag, unit);
					fneg = cneg != (d[k] < 0);
					lim = fneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
					if (fmag > lim) begin
						fmag = lim;
						sat = 1;
					end
					fv[k] = fneg ? (64'd0 - fmag) : fmag;
				end
			end
			r.force_x = fv[0][31:0];
			r.force_y = fv[1][31:0];
			r.force_z = fv[2][31:0];
			r.within_cutoff = in_cut;
			r.saturated = sat;
			return r;
		endfunction

		function void note_pair(pair_t p);
			expected_forces.push_back(pair_force(p));
		endfunction

		function void check_force(force_t got);
			force_t exp_f;
			if (expected_forces.size() == 0) begin
				$error("unexpected result beat");
				fails++;
				return;
			end
			exp_f = expected_forces.pop_front();
			if (got.force_x !== exp_f.force_x) begin
				$error("force_x expected %0d got %0d", exp_f.force_x, got.force_x);
				fails++;
			end
			if (got.force_y !== exp_f.force_y) begin
				$error("force_y expected %0d got %0d", exp_f.force_y, got.force_y);
				fails++;
			end
			if (got.force_z !== exp_f.force_z) begin
				$error("force_z expected %0d got %0d", exp_f.force_z, got.force_z);
				fails++;
			end
			if (got.within_cutoff !== exp_f.within_cutoff) begin
				$error("within_cutoff expected %0b got %0b", exp_f.within_cutoff,
					got.within_cutoff);
				fails++;
			end
			if (got.saturated !== exp_f.saturated) begin
				$error("saturated expected %0b got %0b", exp_f.saturated, got.saturated);
				fails++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] first_x = 0, first_y = 0, first_z = 0;
	logic signed [31:0] second_x = 0, second_y = 0, second_z = 0;
	logic [31:0] first_radius = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] force_x, force_y, force_z;
	logic within_cutoff, saturated;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [wcalj_pkg::CFG_IDX_W-1:0] cfg_index = wcalj_pkg::REG_STRENGTH;
	logic [31:0] cfg_data = 0;

	force_scoreboard sb = new;
	bit quiet = 0;
	int stall_left = 0;
	int cycles = 0;

	wca_lennard_jones_pair_force uut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 5);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_force('{force_x, force_y, force_z, within_cutoff, saturated});

	task automatic send_pair(pair_t p);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		first_x <= p.first_x;
		first_y <= p.first_y;
		first_z <= p.first_z;
		second_x <= p.second_x;
		second_y <= p.second_y;
		second_z <= p.second_z;
		first_radius <= p.first_radius;
		do @(posedge clk); while (in_stall);
		sb.note_pair(p);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.expected_forces.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [wcalj_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.write_reg(idx, value);
	endtask

	task automatic set_regs(logic [31:0] s, logic [31:0] c, logic [31:0] co);
		drain();
		write_reg(wcalj_pkg::REG_STRENGTH, s);
		write_reg(wcalj_pkg::REG_CAP, c);
		write_reg(wcalj_pkg::REG_CUTOFF, co);
	endtask

	function automatic logic signed [31:0] near_offset();
		logic signed [31:0] o;
		o = $urandom_range(0, 100000);
		return $urandom_range(0, 1) ? -o : o;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int mode;
		int k;
		logic [31:0] box;
		mode = $urandom_range(0, 9);
		p.first_x = $signed($urandom()) >>> 1;
		p.first_y = $signed($urandom()) >>> 1;
		p.first_z = $signed($urandom()) >>> 1;
		p.second_x = p.first_x - near_offset();
		p.second_y = p.first_y - near_offset();
		p.second_z = p.first_z - near_offset();
		p.first_radius = $urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 8 << FRAC);
		if (mode < 2) begin
			p.first_radius = $urandom_range(1 << (FRAC - 1), 20 << FRAC);
			box = (p.first_radius >> (FRAC - 1)) << FRAC;
			k = $urandom_range(0, 6) - 3;
			p.second_x = p.second_x + k * box;
			p.second_y = p.second_y - k * box;
			p.second_z = p.second_z + box;
		end else if (mode == 2) begin
			p = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom()};
		end
		return p;
	endfunction

	task automatic random_run(int count);
		repeat (count) send_pair(random_pair());
	endtask

	task automatic directed_run();
		send_pair('{0, 0, 0, 0, 0, 0, 0});
		send_pair('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0});
		send_pair('{32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0, 32'hFFFF_FFFF});
		send_pair('{40000, 0, 0, 0, 0, 0, 0});
		send_pair('{0, -40000, 0, 0, 0, 0, 0});
		send_pair('{0, 0, 73561, 0, 0, 0, 0});
		send_pair('{0, 0, 73562, 0, 0, 0, 0});
		send_pair('{10, 20, 30, 0, 0, 0, 0});
		send_pair('{52429, 0, 0, 0, 0, 0, 0});
		send_pair('{60000, 60000, 0, 0, 0, 0, 0});
		send_pair('{100000, 0, 0, 0, 0, 0, 0});
		send_pair('{1 << FRAC, 0, 0, 0, 0, 0, 1 << (FRAC - 1)});
		send_pair('{3 << (FRAC - 1), 0, 0, 0, 0, 0, 1 << FRAC});
		send_pair('{(5 << FRAC) + 30000, 0, 0, 0, 0, 0, 5 << (FRAC - 1)});
		send_pair('{-((7 << FRAC) + 20000), 30000, 0, 0, 0, 0, 7 << (FRAC - 1)});
		send_pair('{5, 5, 5, 5, 5, 5, 32'hFFFF_FFFF});
		send_pair('{1, 0, 0, 0, 0, 0, 0});
		send_pair('{0, 0, 0, 1, 1, 1, 0});
		send_pair('{32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_0000, 0, 0, 0});
		send_pair('{-30000, 30000, -30000, 0, 0, 0, 1234567});
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_run();
		random_run(120);
		drain();
		random_run(120);
		set_regs(32'hFFFF_FFFF, 32'd0, CUTOFF_RST);
		directed_run();
		random_run(120);
		set_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_run(80);
		set_regs(STRENGTH_RST, CAP_RST, 32'd0);
		random_run(50);
		set_regs(32'd1 << 20, 32'd1 << 14, 32'd3 << FRAC);
		random_run(150);
		set_regs(STRENGTH_RST, CAP_RST, CUTOFF_RST);
		quiet = 1;
		random_run(270);
		in_valid <= 0;
		while (sb.expected_forces.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
